[sv/rbi_pkg.sv]
// ----------------------------------------------------------------------------
// Ray/box hit test package
// Shared widths, axis and face codes, stage payload types and helpers.
// ----------------------------------------------------------------------------
package rbi_pkg;

  // Coordinate width of every input field (signed fixed point).
  localparam int COORD_BITS = 32;
  // Differences of two coordinates need one more bit.
  localparam int DIFF_W     = COORD_BITS + 1;
  // Signed product of two DIFF_W values; sums of two such products fit too.
  localparam int PROD_W     = 2 * COORD_BITS + 2;

  localparam int IN_FIELDS  = 12;
  localparam int IN_W       = ((IN_FIELDS * COORD_BITS + 7) / 8) * 8;
  localparam int OUT_BITS   = 4;
  localparam int OUT_W      = ((OUT_BITS + 7) / 8) * 8;

  // Field slots inside the input tdata, in coordinate-sized units.
  localparam int FLD_START  = 0;
  localparam int FLD_DIR    = 3;
  localparam int FLD_LO     = 6;
  localparam int FLD_HI     = 9;

  localparam int NUM_AXES   = 3;
  localparam int NUM_FACES  = 6;

  localparam logic [1:0] AX_X = 2'd0;
  localparam logic [1:0] AX_Y = 2'd1;
  localparam logic [1:0] AX_Z = 2'd2;

  // Faces in test order.
  localparam int FACE_ZMIN = 0;
  localparam int FACE_ZMAX = 1;
  localparam int FACE_YMIN = 2;
  localparam int FACE_YMAX = 3;
  localparam int FACE_XMIN = 4;
  localparam int FACE_XMAX = 5;

  // Normal axis of each face.
  localparam logic [1:0] FACE_NORM [NUM_FACES] = '{AX_Z, AX_Z, AX_Y, AX_Y, AX_X, AX_X};
  // The two in-plane axes for each normal axis.
  localparam logic [1:0] OTHER_AX [NUM_AXES][2] = '{'{AX_Y, AX_Z},
                                                    '{AX_X, AX_Z},
                                                    '{AX_X, AX_Y}};

  typedef enum logic [2:0] {
    RSN_MISS   = 3'd0,
    RSN_INSIDE = 3'd1,
    RSN_ZMIN   = 3'd2,
    RSN_ZMAX   = 3'd3,
    RSN_YMIN   = 3'd4,
    RSN_YMAX   = 3'd5,
    RSN_XMIN   = 3'd6,
    RSN_XMAX   = 3'd7
  } reason_t;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [DIFF_W-1:0]     diff_t;
  typedef logic        [COORD_BITS-1:0] mag_t;
  typedef logic signed [PROD_W-1:0]     prod_t;

  // First stage: differences, magnitudes of the directions, face distances.
  typedef struct packed {
    diff_t  [NUM_AXES-1:0]  dlo;
    diff_t  [NUM_AXES-1:0]  dhi;
    coord_t [NUM_AXES-1:0]  dir;
    mag_t   [NUM_AXES-1:0]  den;
    mag_t   [NUM_FACES-1:0] num;
    logic   [NUM_FACES-1:0] live;
    logic                   enclosed;
  } prep_t;

  // Second stage: cross products.
  typedef struct packed {
    prod_t [NUM_AXES-1:0][1:0]  plo;
    prod_t [NUM_AXES-1:0][1:0]  phi;
    prod_t [NUM_FACES-1:0][1:0] m;
    logic  [NUM_FACES-1:0]      live;
    logic                       enclosed;
  } prod_stage_t;

  // Third stage: per-face verdicts.
  typedef struct packed {
    logic [NUM_FACES-1:0] face_hit;
    logic                 enclosed;
  } eval_t;

  function automatic logic diff_pos(input diff_t v);
    return !v[DIFF_W-1] && (v != '0);
  endfunction

  function automatic logic prod_pos(input prod_t v);
    return !v[PROD_W-1] && (v != '0);
  endfunction

endpackage

[sv/rbi_prep.sv]
// ----------------------------------------------------------------------------
// Ray/box hit test, preparation stage
// Forms coordinate differences, the inside test and the per-face distances.
// ----------------------------------------------------------------------------
module rbi_prep (
  input  logic            clk,
  input  logic            load,
  input  rbi_pkg::coord_t start  [3],
  input  rbi_pkg::coord_t dir    [3],
  input  rbi_pkg::coord_t box_lo [3],
  input  rbi_pkg::coord_t box_hi [3],
  output rbi_pkg::prep_t  prep_r
);
  import rbi_pkg::*;

  prep_t prep_nxt;
  diff_t dlo [NUM_AXES];
  diff_t dhi [NUM_AXES];
  diff_t raw [NUM_FACES];
  logic  dneg [NUM_AXES];
  logic  dzero [NUM_AXES];
  logic  rneg [NUM_FACES];
  logic  rpos [NUM_FACES];

  always_comb begin
    prep_nxt          = '0;
    prep_nxt.enclosed = 1'b1;
    for (int a = 0; a < NUM_AXES; a++) begin
      dlo[a]   = DIFF_W'(start[a]) - DIFF_W'(box_lo[a]);
      dhi[a]   = DIFF_W'(box_hi[a]) - DIFF_W'(start[a]);
      dneg[a]  = dir[a][COORD_BITS-1];
      dzero[a] = (dir[a] == '0);
      prep_nxt.dlo[a] = dlo[a];
      prep_nxt.dhi[a] = dhi[a];
      prep_nxt.dir[a] = dir[a];
      prep_nxt.den[a] = dneg[a] ? mag_t'(-dir[a]) : mag_t'(dir[a]);
      prep_nxt.enclosed = prep_nxt.enclosed && diff_pos(dlo[a]) && diff_pos(dhi[a]);
    end
    // Distance from the start to each face plane along its normal, folded so
    // that it is never negative once the direction points towards the plane.
    for (int f = 0; f < NUM_FACES; f++) begin
      raw[f]  = (f % 2 == 1) ? dhi[FACE_NORM[f]] : -dlo[FACE_NORM[f]];
      rneg[f] = raw[f][DIFF_W-1];
      rpos[f] = !rneg[f] && (raw[f] != '0);
      prep_nxt.live[f] = !dzero[FACE_NORM[f]] &&
                         !(rneg[f] && !dneg[FACE_NORM[f]]) &&
                         !(rpos[f] && dneg[FACE_NORM[f]]);
      prep_nxt.num[f]  = dneg[FACE_NORM[f]] ? mag_t'(-raw[f]) : mag_t'(raw[f]);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      prep_r <= prep_nxt;
    end
  end

endmodule

[sv/rbi_mul.sv]
// ----------------------------------------------------------------------------
// Ray/box hit test, multiplier stage
// Cross-multiplies bound distances by the direction magnitude and the
// in-plane directions by the face distance.
// ----------------------------------------------------------------------------
module rbi_mul (
  input  logic                 clk,
  input  logic                 load,
  input  rbi_pkg::prep_t       prep_r,
  output rbi_pkg::prod_stage_t prod_r
);
  import rbi_pkg::*;

  prod_stage_t prod_nxt;

  always_comb begin
    prod_nxt          = '0;
    prod_nxt.live     = prep_r.live;
    prod_nxt.enclosed = prep_r.enclosed;
    // Bound terms depend only on the normal axis, so both faces share them.
    for (int n = 0; n < NUM_AXES; n++) begin
      for (int k = 0; k < 2; k++) begin
        prod_nxt.plo[n][k] = $signed(prep_r.dlo[OTHER_AX[n][k]]) *
                             $signed({1'b0, prep_r.den[n]});
        prod_nxt.phi[n][k] = $signed(prep_r.dhi[OTHER_AX[n][k]]) *
                             $signed({1'b0, prep_r.den[n]});
      end
    end
    for (int f = 0; f < NUM_FACES; f++) begin
      for (int k = 0; k < 2; k++) begin
        prod_nxt.m[f][k] = $signed(prep_r.dir[OTHER_AX[FACE_NORM[f]][k]]) *
                           $signed({1'b0, prep_r.num[f]});
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      prod_r <= prod_nxt;
    end
  end

endmodule

[sv/rbi_eval.sv]
// ----------------------------------------------------------------------------
// Ray/box hit test, evaluation stage
// Checks that each face crossing lies strictly inside the face's bounds.
// ----------------------------------------------------------------------------
module rbi_eval (
  input  logic                 clk,
  input  logic                 load,
  input  rbi_pkg::prod_stage_t prod_r,
  output rbi_pkg::eval_t       eval_r
);
  import rbi_pkg::*;

  eval_t eval_nxt;
  prod_t above [NUM_FACES][2];
  prod_t below [NUM_FACES][2];

  always_comb begin
    eval_nxt          = '0;
    eval_nxt.enclosed = prod_r.enclosed;
    for (int f = 0; f < NUM_FACES; f++) begin
      eval_nxt.face_hit[f] = prod_r.live[f];
      for (int k = 0; k < 2; k++) begin
        above[f][k] = $signed(prod_r.plo[FACE_NORM[f]][k]) + $signed(prod_r.m[f][k]);
        below[f][k] = $signed(prod_r.phi[FACE_NORM[f]][k]) - $signed(prod_r.m[f][k]);
        eval_nxt.face_hit[f] = eval_nxt.face_hit[f] &&
                               prod_pos(above[f][k]) && prod_pos(below[f][k]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      eval_r <= eval_nxt;
    end
  end

endmodule

[sv/ray_box_intersection_test.sv]
// ----------------------------------------------------------------------------
// Ray versus axis-aligned box hit test
// Four-stage pipeline: prepare, multiply, evaluate, encode and output.
// ----------------------------------------------------------------------------
// Usage: each input transaction carries one ray start, one ray direction and
// one box, all as signed fixed-point coordinates. Each produces exactly one
// output transaction with the hit flag and the reason: inside, or the first
// face crossed in the order z_min, z_max, y_min, y_max, x_min, x_max, or a
// miss. The comparisons are exact cross-multiplications, so the fraction
// width does not affect the answer.
// Throughput is one transaction per cycle while the receiver keeps out_tready
// high. A result passes one register each for the differences, the cross
// products, the sign tests and the output before out_tvalid rises.
// The product stage sets the clock rate of the block.
// Reset (rst_n low, synchronous) empties the pipeline; in_tready is low
// while reset is held. When the receiver stalls, the result holds in the
// output register while the earlier stages keep accepting until every
// stage is full; then in_tready falls. Nothing is dropped or repeated.
// ----------------------------------------------------------------------------
module ray_box_intersection_test (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_tvalid,
  output logic                      in_tready,
  // Fields from bit 0 up, 32 bits each: start_x, start_y, start_z, dir_x,
  // dir_y, dir_z, box_x_min, box_y_min, box_z_min, box_x_max, box_y_max,
  // box_z_max.
  input  logic [rbi_pkg::IN_W-1:0]  in_tdata,
  output logic                      out_tvalid,
  input  logic                      out_tready,
  // Fields from bit 0 up: hit (1 bit), hit_reason (3 bits), zero padding.
  output logic [rbi_pkg::OUT_W-1:0] out_tdata
);
  import rbi_pkg::*;

  coord_t      start  [NUM_AXES];
  coord_t      dir    [NUM_AXES];
  coord_t      box_lo [NUM_AXES];
  coord_t      box_hi [NUM_AXES];
  prep_t       prep_r;
  prod_stage_t prod_r;
  eval_t       eval_r;

  // Valid bits travelling with the stage payloads.
  logic v1_r, v1_nxt;
  logic v2_r, v2_nxt;
  logic v3_r, v3_nxt;
  logic out_valid_r, out_valid_nxt;
  logic [OUT_W-1:0] out_data_r, out_data_nxt;
  logic en1, en2, en3, en_out;
  reason_t reason;

  // Unpack the input transaction into per-axis coordinates.
  always_comb begin
    for (int a = 0; a < NUM_AXES; a++) begin
      start[a]  = coord_t'(in_tdata[(FLD_START + a) * COORD_BITS +: COORD_BITS]);
      dir[a]    = coord_t'(in_tdata[(FLD_DIR + a) * COORD_BITS +: COORD_BITS]);
      box_lo[a] = coord_t'(in_tdata[(FLD_LO + a) * COORD_BITS +: COORD_BITS]);
      box_hi[a] = coord_t'(in_tdata[(FLD_HI + a) * COORD_BITS +: COORD_BITS]);
    end
  end

  // A stage loads when it is empty or when the stage after it moves on, so
  // bubbles close up behind a stalled output.
  assign en_out    = !out_valid_r || out_tready;
  assign en3       = !v3_r || en_out;
  assign en2       = !v2_r || en3;
  assign en1       = !v1_r || en2;
  assign in_tready = en1 && rst_n;

  rbi_prep u_prep (
    .clk    (clk),
    .load   (en1),
    .start  (start),
    .dir    (dir),
    .box_lo (box_lo),
    .box_hi (box_hi),
    .prep_r (prep_r)
  );

  rbi_mul u_mul (
    .clk    (clk),
    .load   (en2),
    .prep_r (prep_r),
    .prod_r (prod_r)
  );

  rbi_eval u_eval (
    .clk    (clk),
    .load   (en3),
    .prod_r (prod_r),
    .eval_r (eval_r)
  );

  // The first face in test order wins; a start inside the box beats them all.
  always_comb begin
    if (eval_r.enclosed) begin
      reason = RSN_INSIDE;
    end else if (eval_r.face_hit[FACE_ZMIN]) begin
      reason = RSN_ZMIN;
    end else if (eval_r.face_hit[FACE_ZMAX]) begin
      reason = RSN_ZMAX;
    end else if (eval_r.face_hit[FACE_YMIN]) begin
      reason = RSN_YMIN;
    end else if (eval_r.face_hit[FACE_YMAX]) begin
      reason = RSN_YMAX;
    end else if (eval_r.face_hit[FACE_XMIN]) begin
      reason = RSN_XMIN;
    end else if (eval_r.face_hit[FACE_XMAX]) begin
      reason = RSN_XMAX;
    end else begin
      reason = RSN_MISS;
    end
    out_data_nxt = {{(OUT_W - OUT_BITS){1'b0}}, reason, (reason != RSN_MISS)};
  end

  always_comb begin
    v1_nxt        = en1 ? (in_tvalid && in_tready) : v1_r;
    v2_nxt        = en2 ? v1_r : v2_r;
    v3_nxt        = en3 ? v2_r : v3_r;
    out_valid_nxt = en_out ? v3_r : out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      v1_r        <= v1_nxt;
      v2_r        <= v2_nxt;
      v3_r        <= v3_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en_out) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

[sv/rbi_checker.sv]
// ----------------------------------------------------------------------------
// Ray/box hit test checker
// Port-level assertions on the hit test, bound to the top level.
// ----------------------------------------------------------------------------
module rbi_checker (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_tvalid,
  input logic                      in_tready,
  input logic                      out_tvalid,
  input logic                      out_tready,
  input logic [rbi_pkg::OUT_W-1:0] out_tdata
);
  import rbi_pkg::*;

  // A stalled result stays offered and unchanged.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed or vanished");

  // The hit flag agrees with the reason code.
  a_hit_reason: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[0] == (out_tdata[3:1] != RSN_MISS)))
    else $error("hit flag disagrees with reason");

  // Padding bits of the result stay clear.
  a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[OUT_W-1:OUT_BITS] == '0))
    else $error("result padding bits not zero");

  // With the receiver ready throughout, a result appears once its transaction
  // has passed the preparation, product, evaluation and output registers.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    $past(in_tvalid && in_tready, 4) && $past(rst_n, 4) && $past(rst_n, 3) &&
    $past(rst_n, 2) && $past(rst_n, 1) && $past(out_tready, 3) &&
    $past(out_tready, 2) && $past(out_tready, 1) |-> out_tvalid)
    else $error("result missing after pipeline latency");

endmodule

bind ray_box_intersection_test rbi_checker u_rbi_checker (.*);
